FILE: src/lpbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Leg posture balance controller package
// Item types, configuration fields, microcode control word and the program.
// ----------------------------------------------------------------------------
package lpbc_pkg;

  localparam int STEP_W   = 5;
  localparam int A_W      = 21;  // multiplier operand A, signed
  localparam int B_W      = 16;  // multiplier operand B, unsigned
  localparam int PROD_W   = A_W + B_W + 1;
  localparam int ACC_W    = 40;

  localparam logic [15:0]        ALPHA_Q16   = 16'd62259;  // 0.95 in Q0.16
  localparam logic [15:0]        BETA_Q16    = 16'd3277;   // 0.05 in Q0.16
  localparam logic signed [15:0] STILL_BAND  = 16'sd307;   // 1.2 in Q8.8
  localparam logic signed [13:0] X_OFF_LIMIT = 14'sd5120;  // 20.0 in Q6.8

  typedef struct packed {
    logic signed [16:0] roll_angle;
    logic signed [19:0] roll_rate;
    logic signed [15:0] speed_target;
    logic signed [15:0] speed_measured;
    logic [15:0]        left_height_cmd;
    logic [15:0]        right_height_cmd;
  } in_item_t;

  typedef struct packed {
    logic [15:0] leg_x;
    logic [15:0] left_height;
    logic [15:0] right_height;
  } out_item_t;

  typedef struct packed {
    logic [12:0]        roll_dead_band;
    logic [11:0]        roll_gain_p;
    logic [11:0]        roll_gain_d;
    logic signed [13:0] roll_setpoint;
    logic signed [12:0] roll_zero_offset;
    logic [11:0]        speed_gain_drive;
    logic [11:0]        speed_gain_brake;
    logic [14:0]        speed_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_ROLL_DEAD_BAND   = 3'd0,
    CFG_ROLL_GAIN_P      = 3'd1,
    CFG_ROLL_GAIN_D      = 3'd2,
    CFG_ROLL_SETPOINT    = 3'd3,
    CFG_ROLL_ZERO_OFFSET = 3'd4,
    CFG_SPEED_GAIN_DRIVE = 3'd5,
    CFG_SPEED_GAIN_BRAKE = 3'd6,
    CFG_SPEED_LIMIT      = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MA_ROLL,
    MA_FILT,
    MA_ERR,
    MA_RATE,
    MA_SERR
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_ALPHA,
    MB_BETA,
    MB_KP,
    MB_KD,
    MB_GAIN
  } mul_b_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_FILT,
    WR_ERR,
    WR_DZ,
    WR_OFF,
    WR_OFF_ZERO,
    WR_HEIGHT,
    WR_SPD,
    WR_XO,
    WR_XO_ZERO,
    WR_X
  } wr_e;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_DEAD,
    JMP_STILL,
    JMP_END
  } jmp_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    mul_a_e             mul_a;
    mul_b_e             mul_b;
    logic               mul_en;
    acc_op_e            acc_op;
    wr_e                wr;
    jmp_e               jmp;
    logic [STEP_W-1:0]  target;
  } ucw_t;

  typedef struct packed {
    logic run;
    ucw_t uw;
  } seq_ctrl_t;

  typedef struct packed {
    logic dead;
    logic still;
  } dp_status_t;

  // Jump labels
  localparam logic [STEP_W-1:0] STEP_OFF_ZERO = 5'd10;
  localparam logic [STEP_W-1:0] STEP_HEIGHT   = 5'd11;
  localparam logic [STEP_W-1:0] STEP_XO_ZERO  = 5'd16;
  localparam logic [STEP_W-1:0] STEP_X        = 5'd17;

  // Control store: one word per step
  function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
    ucw_t w;
    w.mul_a  = MA_ROLL;
    w.mul_b  = MB_ALPHA;
    w.mul_en = 1'b0;
    w.acc_op = ACC_HOLD;
    w.wr     = WR_NONE;
    w.jmp    = JMP_NONE;
    w.target = '0;
    case (step)
      5'd0: begin
        w.mul_a = MA_ROLL; w.mul_b = MB_ALPHA; w.mul_en = 1'b1;
      end
      5'd1: begin
        w.mul_a = MA_FILT; w.mul_b = MB_BETA; w.mul_en = 1'b1; w.acc_op = ACC_LOAD;
      end
      5'd2: w.acc_op = ACC_ADD;
      5'd3: w.wr = WR_FILT;
      5'd4: w.wr = WR_ERR;
      5'd5: w.wr = WR_DZ;
      5'd6: begin
        w.mul_a = MA_ERR; w.mul_b = MB_KP; w.mul_en = 1'b1;
        w.jmp = JMP_DEAD; w.target = STEP_OFF_ZERO;
      end
      5'd7: begin
        w.mul_a = MA_RATE; w.mul_b = MB_KD; w.mul_en = 1'b1; w.acc_op = ACC_LOAD;
      end
      5'd8: w.acc_op = ACC_SUB;
      5'd9: begin
        w.wr = WR_OFF; w.jmp = JMP_ALWAYS; w.target = STEP_HEIGHT;
      end
      5'd10: w.wr = WR_OFF_ZERO;
      5'd11: w.wr = WR_HEIGHT;
      5'd12: w.wr = WR_SPD;
      5'd13: begin
        w.mul_a = MA_SERR; w.mul_b = MB_GAIN; w.mul_en = 1'b1;
        w.jmp = JMP_STILL; w.target = STEP_XO_ZERO;
      end
      5'd14: w.acc_op = ACC_LOAD;
      5'd15: begin
        w.wr = WR_XO; w.jmp = JMP_ALWAYS; w.target = STEP_X;
      end
      5'd16: w.wr = WR_XO_ZERO;
      5'd17: begin
        w.wr = WR_X; w.jmp = JMP_END;
      end
      default: w.jmp = JMP_END;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: src/lpbc_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the control store, with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module lpbc_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  out_free_i,
  input  wire lpbc_pkg::dp_status_t  status_i,
  output lpbc_pkg::seq_ctrl_t        ctrl_o,
  output logic                       busy_o
);
  import lpbc_pkg::*;

  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  ucw_t              uw;
  logic              taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    uw      = ucode_rom(step_q);
    state_d = state_q;
    step_d  = step_q;
    ctrl_o.run = 1'b0;
    ctrl_o.uw  = uw;
    taken = (uw.jmp == JMP_ALWAYS) ||
            ((uw.jmp == JMP_DEAD) && status_i.dead) ||
            ((uw.jmp == JMP_STILL) && status_i.still);
    case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = SEQ_RUN;
          step_d  = '0;
        end
      end
      SEQ_RUN: begin
        if (uw.jmp == JMP_END) begin
          // hold the last step until the output register is free
          if (out_free_i) begin
            ctrl_o.run = 1'b1;
            state_d    = SEQ_IDLE;
            step_d     = '0;
          end
        end else begin
          ctrl_o.run = 1'b1;
          step_d     = taken ? uw.target : step_q + STEP_W'(1);
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  assign busy_o = (state_q == SEQ_RUN);

endmodule
`default_nettype wire

FILE: src/lpbc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Controller datapath
// One shared multiplier, accumulator and the working registers of the tick.
// ----------------------------------------------------------------------------
module lpbc_dp #(
  parameter logic [15:0] HEIGHT_MIN = 16'd15360,
  parameter logic [15:0] HEIGHT_MAX = 16'd28160,
  parameter logic [15:0] X_CENTER   = 16'd5632,
  parameter logic [15:0] X_MIN      = 16'd0,
  parameter logic [15:0] X_MAX      = 16'd11264
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire lpbc_pkg::in_item_t   in_data_i,
  input  wire lpbc_pkg::cfg_t       cfg_i,
  input  wire lpbc_pkg::seq_ctrl_t  ctrl_i,
  output lpbc_pkg::dp_status_t      status_o,
  output lpbc_pkg::out_item_t       out_data_o
);
  import lpbc_pkg::*;

  in_item_t                  in_q;
  logic signed [17:0]        filt_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [18:0]        err_q, err_d, e_q;
  logic                      dead_q, still_q, tzero_q;
  logic signed [24:0]        off_q;
  logic [15:0]               left_q, right_q;
  logic signed [17:0]        serr_q, serr_d;
  logic signed [13:0]        xo_q, xo_d;
  out_item_t                 out_q;

  logic signed [A_W-1:0]     mul_a;
  logic [B_W-1:0]            mul_b;
  logic signed [B_W:0]       mul_b_s;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [ACC_W-1:0]   prod_x, acc_sh16, acc_sh8;

  logic signed [18:0]        sp_x, filt_x, zo_x, db_x, ndb_x;
  logic signed [25:0]        cmdl_x, cmdr_x, off_x, yl_raw, yr_raw;
  logic signed [16:0]        tgt_x, lim_x, nlim_x, tc;
  logic signed [17:0]        tc_x, meas_x, xc_x, xo_x, x_raw;
  logic                      run;

  function automatic logic [15:0] clamp_h(input logic signed [25:0] v);
    logic signed [25:0] lo, hi, t;
    lo = $signed({10'b0, HEIGHT_MIN});
    hi = $signed({10'b0, HEIGHT_MAX});
    t  = (v > hi) ? hi : v;
    t  = (t < lo) ? lo : t;
    return t[15:0];
  endfunction

  function automatic logic [15:0] clamp_x(input logic signed [17:0] v);
    logic signed [17:0] lo, hi, t;
    lo = $signed({2'b0, X_MIN});
    hi = $signed({2'b0, X_MAX});
    t  = (v > hi) ? hi : v;
    t  = (t < lo) ? lo : t;
    return t[15:0];
  endfunction

  assign run = ctrl_i.run;

  // Operand selection
  always_comb begin
    case (ctrl_i.uw.mul_a)
      MA_ROLL: mul_a = {{(A_W-17){in_q.roll_angle[16]}}, in_q.roll_angle};
      MA_FILT: mul_a = {{(A_W-18){filt_q[17]}}, filt_q};
      MA_ERR:  mul_a = {{(A_W-19){e_q[18]}}, e_q};
      MA_RATE: mul_a = {{(A_W-20){in_q.roll_rate[19]}}, in_q.roll_rate};
      MA_SERR: mul_a = {{(A_W-18){serr_q[17]}}, serr_q};
      default: mul_a = '0;
    endcase
    case (ctrl_i.uw.mul_b)
      MB_ALPHA: mul_b = ALPHA_Q16;
      MB_BETA:  mul_b = BETA_Q16;
      MB_KP:    mul_b = {4'b0, cfg_i.roll_gain_p};
      MB_KD:    mul_b = {4'b0, cfg_i.roll_gain_d};
      MB_GAIN:  mul_b = {4'b0, tzero_q ? cfg_i.speed_gain_brake : cfg_i.speed_gain_drive};
      default:  mul_b = '0;
    endcase
  end

  assign mul_b_s = {1'b0, mul_b};
  assign prod_d  = mul_a * mul_b_s;
  assign prod_x  = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    case (ctrl_i.uw.acc_op)
      ACC_LOAD: acc_d = prod_x;
      ACC_ADD:  acc_d = acc_q + prod_x;
      ACC_SUB:  acc_d = acc_q - prod_x;
      default:  acc_d = acc_q;
    endcase
  end

  // Round half up, then arithmetic shift
  assign acc_sh16 = (acc_q + 40'sd32768) >>> 16;
  assign acc_sh8  = (acc_q + 40'sd128) >>> 8;

  // Roll error
  assign sp_x   = {{5{cfg_i.roll_setpoint[13]}}, cfg_i.roll_setpoint};
  assign filt_x = {filt_q[17], filt_q};
  assign zo_x   = {{6{cfg_i.roll_zero_offset[12]}}, cfg_i.roll_zero_offset};
  assign err_d  = sp_x - filt_x - zo_x;
  assign db_x   = {6'b0, cfg_i.roll_dead_band};
  assign ndb_x  = -db_x;

  // Heights
  assign cmdl_x = {10'b0, in_q.left_height_cmd};
  assign cmdr_x = {10'b0, in_q.right_height_cmd};
  assign off_x  = {off_q[24], off_q};
  assign yl_raw = cmdl_x - off_x;
  assign yr_raw = cmdr_x + off_x;

  // Speed target clamp and speed error
  assign tgt_x  = {in_q.speed_target[15], in_q.speed_target};
  assign lim_x  = {2'b0, cfg_i.speed_limit};
  assign nlim_x = -lim_x;
  always_comb begin
    tc = (tgt_x > lim_x) ? lim_x : tgt_x;
    tc = (tc < nlim_x) ? nlim_x : tc;
  end
  assign tc_x   = {tc[16], tc};
  assign meas_x = {{2{in_q.speed_measured[15]}}, in_q.speed_measured};
  assign serr_d = tc_x - meas_x;

  always_comb begin
    if (acc_sh8 > X_OFF_LIMIT) begin
      xo_d = X_OFF_LIMIT;
    end else if (acc_sh8 < -X_OFF_LIMIT) begin
      xo_d = -X_OFF_LIMIT;
    end else begin
      xo_d = acc_sh8[13:0];
    end
  end

  assign xc_x  = {2'b0, X_CENTER};
  assign xo_x  = {{4{xo_q[13]}}, xo_q};
  assign x_raw = xc_x - xo_x;

  // Filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
    end else if (run && (ctrl_i.uw.wr == WR_FILT)) begin
      filt_q <= acc_sh16[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      in_q <= in_data_i;
    end
    if (run && ctrl_i.uw.mul_en) begin
      prod_q <= prod_d;
    end
    if (run) begin
      acc_q <= acc_d;
      case (ctrl_i.uw.wr)
        WR_ERR: err_q <= err_d;
        WR_DZ: begin
          if (err_q > db_x) begin
            e_q    <= err_q - db_x;
            dead_q <= 1'b0;
          end else if (err_q < ndb_x) begin
            e_q    <= err_q + db_x;
            dead_q <= 1'b0;
          end else begin
            e_q    <= '0;
            dead_q <= 1'b1;
          end
        end
        WR_OFF:      off_q <= acc_sh8[24:0];
        WR_OFF_ZERO: off_q <= '0;
        WR_HEIGHT: begin
          left_q  <= clamp_h(yl_raw);
          right_q <= clamp_h(yr_raw);
        end
        WR_SPD: begin
          serr_q  <= serr_d;
          tzero_q <= (tc == 17'sd0);
          still_q <= (tc == 17'sd0) && (in_q.speed_measured <= STILL_BAND) &&
                     (in_q.speed_measured >= -STILL_BAND);
        end
        WR_XO:      xo_q <= xo_d;
        WR_XO_ZERO: xo_q <= '0;
        WR_X: begin
          out_q.leg_x        <= clamp_x(x_raw);
          out_q.left_height  <= left_q;
          out_q.right_height <= right_q;
        end
        default: ;
      endcase
    end
  end

  assign status_o.dead  = dead_q;
  assign status_o.still = still_q;
  assign out_data_o     = out_q;

endmodule
`default_nettype wire

FILE: src/leg_posture_balance_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Leg posture balance controller
// PD roll levelling with dead zone and roll low-pass, plus speed-driven leg X.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o    in_data_i   (in_item_t)
//   out      source     out_valid_o/out_stall_i  out_data_o  (out_item_t)
//   cfg      sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// An item is registered on acceptance and runs 13 to 16 microcode steps (16
// in full, 2 fewer inside the roll dead zone, 1 fewer at standstill), with its
// products through the one shared 21x17 multiplier; the result is valid after
// the last step, and no new item is taken until the cycle after it. Reset
// clears the filtered roll and sets the configuration registers to defaults.
// A stalled result holds the last step, and with it the input, until taken.
// ----------------------------------------------------------------------------
module leg_posture_balance_controller_top #(
  parameter logic [15:0] HEIGHT_MIN = 16'd15360,
  parameter logic [15:0] HEIGHT_MAX = 16'd28160,
  parameter logic [15:0] X_CENTER   = 16'd5632,
  parameter logic [15:0] X_MIN      = 16'd0,
  parameter logic [15:0] X_MAX      = 16'd11264
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire lpbc_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output lpbc_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);
  import lpbc_pkg::*;

  cfg_t       cfg_q;
  seq_ctrl_t  ctrl;
  dp_status_t status;
  logic       busy, accept, emit, out_free, out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit        = ctrl.run && (ctrl.uw.jmp == JMP_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roll_dead_band   <= 13'd768;
      cfg_q.roll_gain_p      <= 12'd384;
      cfg_q.roll_gain_d      <= 12'd0;
      cfg_q.roll_setpoint    <= 14'sd0;
      cfg_q.roll_zero_offset <= -13'sd730;
      cfg_q.speed_gain_drive <= 12'd128;
      cfg_q.speed_gain_brake <= 12'd1024;
      cfg_q.speed_limit      <= 15'd5120;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ROLL_DEAD_BAND:   cfg_q.roll_dead_band   <= cfg_data_i[12:0];
        CFG_ROLL_GAIN_P:      cfg_q.roll_gain_p      <= cfg_data_i[11:0];
        CFG_ROLL_GAIN_D:      cfg_q.roll_gain_d      <= cfg_data_i[11:0];
        CFG_ROLL_SETPOINT:    cfg_q.roll_setpoint    <= cfg_data_i[13:0];
        CFG_ROLL_ZERO_OFFSET: cfg_q.roll_zero_offset <= cfg_data_i[12:0];
        CFG_SPEED_GAIN_DRIVE: cfg_q.speed_gain_drive <= cfg_data_i[11:0];
        CFG_SPEED_GAIN_BRAKE: cfg_q.speed_gain_brake <= cfg_data_i[11:0];
        CFG_SPEED_LIMIT:      cfg_q.speed_limit      <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Output valid: set by the last step, drop when the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  lpbc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .out_free_i (out_free),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  lpbc_dp #(
    .HEIGHT_MIN (HEIGHT_MIN),
    .HEIGHT_MAX (HEIGHT_MAX),
    .X_CENTER   (X_CENTER),
    .X_MIN      (X_MIN),
    .X_MAX      (X_MAX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not start the step program");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(emit))
    else $error("result valid rose without a final step");

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !(out_valid_q && out_stall_i))
    else $error("final step overwrote a stalled result");

endmodule
`default_nettype wire
